>>> hw/rtl/ring_queue_with_rounded_mean_top_defines.svh
// Assertion macros shared by the ring queue RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef RING_QUEUE_WITH_ROUNDED_MEAN_TOP_DEFINES_SVH
`define RING_QUEUE_WITH_ROUNDED_MEAN_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RQM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RQM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/rqm_pkg.sv
// Shared constants, command codes and controller state type for the ring queue.
// No dependencies; imported by the interfaces, rqm_div and the top module.
package rqm_pkg;

  localparam int DEPTH      = 5;
  localparam int FIELD_W    = 12;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = FIELD_W + CNT_W;
  localparam int NUM_W      = SUM_W + 1;
  localparam int DEN_W      = CNT_W + 1;
  localparam int ENTRY_W    = 2 * FIELD_W;
  localparam int DIV_DIGITS = 4;
  localparam int DIV_CYCLES = FIELD_W / DIV_DIGITS;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } rqm_state_t;

endpackage

>>> hw/rtl/rqm_req_if.sv
// Command channel of the ring queue: valid/ready plus command, value and tag.
// Depends on rqm_pkg for the field width.
interface rqm_req_if import rqm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [FIELD_W-1:0] value;
  logic [FIELD_W-1:0] tag;

  modport source (output valid, cmd, value, tag, input ready);
  modport sink   (input valid, cmd, value, tag, output ready);
endinterface

>>> hw/rtl/rqm_rsp_if.sv
// Result channel of the ring queue: valid/ready plus the result fields.
// Depends on rqm_pkg for the field width.
interface rqm_rsp_if import rqm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               was_insert;
  logic [FIELD_W-1:0] mean;
  logic               popped_valid;
  logic [FIELD_W-1:0] popped_tag;
  logic [FIELD_W-1:0] popped_value;

  modport source (output valid, was_insert, mean, popped_valid, popped_tag, popped_value,
                  input ready);
  modport sink   (input valid, was_insert, mean, popped_valid, popped_tag, popped_value,
                  output ready);
endinterface

>>> hw/rtl/rqm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rqm_ram #(
  parameter int WIDTH = 24,
  parameter int WORDS = 5,
  localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/rqm_div.sv
// Multi-cycle divider for the rounded mean, four quotient bits per cycle.
// Depends on rqm_pkg for operand widths; the quotient is known to fit FIELD_W bits.
module rqm_div import rqm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]   den,
  output logic               done,
  output logic [FIELD_W-1:0] quot
);

  localparam int STEP_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   rem_next;
  logic [FIELD_W-1:0] low;
  logic [FIELD_W-1:0] low_next;
  logic [FIELD_W-1:0] quot_next;
  logic [DEN_W-1:0]   den_q;

  // Restoring long division; the remainder always stays below the divisor.
  always_comb begin : digit_steps
    logic [DEN_W:0]     r_v;
    logic [DEN_W-1:0]   rem_v;
    logic [FIELD_W-1:0] low_v;
    logic [FIELD_W-1:0] q_v;
    rem_v = rem;
    low_v = low;
    q_v   = quot;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      r_v   = {rem_v, low_v[FIELD_W-1]};
      low_v = {low_v[FIELD_W-2:0], 1'b0};
      q_v   = {q_v[FIELD_W-2:0], 1'b0};
      if (r_v >= {1'b0, den_q}) begin
        r_v    = r_v - {1'b0, den_q};
        q_v[0] = 1'b1;
      end
      rem_v = r_v[DEN_W-1:0];
    end
    rem_next  = rem_v;
    low_next  = low_v;
    quot_next = q_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_W'(DIV_CYCLES - 1);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num[NUM_W-1:FIELD_W];
      low   <= num[FIELD_W-1:0];
      quot  <= '0;
      den_q <= den;
    end else if (busy) begin
      rem  <= rem_next;
      low  <= low_next;
      quot <= quot_next;
    end
  end

endmodule

>>> hw/rtl/ring_queue_with_rounded_mean_top.sv
// Ring queue of DEPTH entries (value and tag) with a rounded running mean.
// Request channel req carries cmd, value and tag; the result channel rsp carries
// was_insert, mean, popped_valid, popped_tag and popped_value. Each request
// transaction produces exactly one result transaction, in order.
// Entries live in a RAM with registered read data; head, tail, fill count and the
// running sum are registers. One request is processed at a time: the head
// entry is read in the accept cycle and consumed the cycle after.
// A remove passes through the states POP and DONE before the next accept; an
// insert also passes through DIV_START and DIV_WAIT, where the divider forms
// (2*sum+count)/(2*count) four quotient bits per cycle.
// The result sits in an output register, loaded from state DONE; if rsp is
// stalled the controller holds the finished result and req.ready stays low
// until the output register frees up.
// Synchronous reset empties the queue (count, sum, pointers to zero) and drops
// any pending result; the RAM contents are not cleared and are never used
// before they are written.
// Depends on rqm_pkg, rqm_req_if, rqm_rsp_if, rqm_ram, rqm_div and the defines header.
`include "ring_queue_with_rounded_mean_top_defines.svh"

module ring_queue_with_rounded_mean_top import rqm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rqm_req_if.sink   req,
  rqm_rsp_if.source rsp
);

  rqm_state_t state;
  rqm_state_t state_next;

  logic               cmd_q;
  logic [FIELD_W-1:0] value_q;
  logic [FIELD_W-1:0] tag_q;

  logic [IDX_W-1:0]   head;
  logic [IDX_W-1:0]   head_next;
  logic [IDX_W-1:0]   tail;
  logic [IDX_W-1:0]   tail_next;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [SUM_W-1:0]   sum;
  logic [SUM_W-1:0]   sum_next;

  logic               res_pv;
  logic               res_pv_next;
  logic [FIELD_W-1:0] res_tag;
  logic [FIELD_W-1:0] res_val;

  logic               accept;
  logic               mem_wr_en;
  logic [ENTRY_W-1:0] rd_data;
  logic [FIELD_W-1:0] rd_value;
  logic [FIELD_W-1:0] rd_tag;
  logic               full;
  logic               empty;
  logic               out_free;
  logic               load_out;

  logic               div_start;
  logic               div_done;
  logic [NUM_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic [FIELD_W-1:0] div_quot;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

  assign accept   = req.valid && req.ready;
  assign rd_value = rd_data[FIELD_W-1:0];
  assign rd_tag   = rd_data[ENTRY_W-1:FIELD_W];
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign out_free = !rsp.valid || rsp.ready;
  assign div_num  = {sum, 1'b0} + NUM_W'(count);
  assign div_den  = {count, 1'b0};

  rqm_ram #(
    .WIDTH (ENTRY_W),
    .WORDS (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (tail),
    .wr_data ({tag_q, value_q}),
    .rd_en   (accept),
    .rd_addr (head),
    .rd_data (rd_data)
  );

  rqm_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) state_next = ST_POP;
      end
      ST_POP: begin
        state_next = (cmd_q == CMD_INSERT) ? ST_DIV_START : ST_DONE;
      end
      ST_DIV_START: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    req.ready = 1'b0;
    mem_wr_en = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE:      req.ready = 1'b1;
      ST_POP:       mem_wr_en = (cmd_q == CMD_INSERT);
      ST_DIV_START: div_start = 1'b1;
      ST_DIV_WAIT:  ;
      ST_DONE:      load_out  = out_free;
      default:      ;
    endcase
  end

  // Queue bookkeeping in the cycle the head entry arrives from the RAM.
  // On a full insert the head and tail coincide, so the read precedes the overwrite.
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    count_next  = count;
    sum_next    = sum;
    res_pv_next = 1'b0;
    if (cmd_q == CMD_INSERT) begin
      tail_next = wrap_inc(tail);
      if (full) begin
        head_next = wrap_inc(head);
        sum_next  = sum - SUM_W'(rd_value) + SUM_W'(value_q);
      end else begin
        count_next = count + CNT_W'(1);
        sum_next   = sum + SUM_W'(value_q);
      end
    end else if (!empty) begin
      head_next   = wrap_inc(head);
      count_next  = count - CNT_W'(1);
      sum_next    = sum - SUM_W'(rd_value);
      res_pv_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      sum   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_POP) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
        sum   <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= req.cmd;
      value_q <= req.value;
      tag_q   <= req.tag;
    end
    if (state == ST_POP) begin
      res_pv  <= res_pv_next;
      res_tag <= res_pv_next ? rd_tag : '0;
      res_val <= res_pv_next ? rd_value : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.was_insert   <= (cmd_q == CMD_INSERT);
      rsp.mean         <= (cmd_q == CMD_INSERT) ? div_quot : '0;
      rsp.popped_valid <= res_pv;
      rsp.popped_tag   <= res_tag;
      rsp.popped_value <= res_val;
    end
  end

  `RQM_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(DEPTH), "count overflow")
  `RQM_ASSERT_IMPL(a_ring_align, clk, rst, empty || full, head == tail, "ring misaligned")
  `RQM_ASSERT_NEXT(a_accept_pop, clk, rst, accept, state == ST_POP, "accept without pop")
  `RQM_ASSERT_IMPL(a_div_owner, clk, rst, div_done, state == ST_DIV_WAIT, "stray divide")
  `RQM_ASSERT_IMPL(a_no_overrun, clk, rst, load_out, !rsp.valid || rsp.ready, "result overrun")

endmodule
